[rtl/video_sync_line_tracker_macros.svh]
// Assertion macros used by the video sync line tracker checker.
`ifndef VIDEO_SYNC_LINE_TRACKER_MACROS_SVH
`define VIDEO_SYNC_LINE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VSLT_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vslt assertion failed");

// Next-cycle implication, disabled during reset.
`define VSLT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vslt assertion failed");

`endif

[rtl/vslt_pkg.sv]
// Package of the video sync line tracker: constants, codes and shared types.
package vslt_pkg;

   localparam int GLYPH_HEIGHT   = 18;
   localparam int NTSC_ROW_COUNT = 13;
   localparam int PAL_ROW_COUNT  = 15;

   localparam int PULSE_W = 16;
   localparam int BOUND_W = 15;
   localparam int VOFF_W  = 5;
   localparam int FROW_W  = 4;
   localparam int CSR_W   = 15;
   localparam int IDX_W   = 3;
   localparam int SCAN_W  = 10;
   localparam int SYNC_W  = 8;
   localparam int START_W = 6;
   localparam int LIMIT_W = 9;
   localparam int ROW_W   = 8;
   localparam int FONT_W  = 5;

   localparam logic [LIMIT_W-1:0] NTSC_LIMIT = LIMIT_W'(NTSC_ROW_COUNT * GLYPH_HEIGHT - 1);
   localparam logic [LIMIT_W-1:0] PAL_LIMIT  = LIMIT_W'(PAL_ROW_COUNT * GLYPH_HEIGHT - 1);

   localparam logic [SCAN_W-1:0] SCAN_MAX         = '1;
   localparam logic [SYNC_W-1:0] SYNC_MAX         = '1;
   localparam logic [ROW_W-1:0]  ROW_MAX          = '1;
   localparam logic [SCAN_W-1:0] LINES_SET_FIELD1 = 10'd254;
   localparam logic [SCAN_W-1:0] LINES_SET_FIELD0 = 10'd253;
   localparam logic [SCAN_W-1:0] LINES_PAL        = 10'd305;
   localparam logic [SYNC_W-1:0] PAL_SYNC_RUN     = 8'd12;

   typedef enum logic [1:0] {
      CLASS_LINE  = 2'd0,
      CLASS_SYNC  = 2'd1,
      CLASS_OTHER = 2'd2
   } vslt_class_type;

   typedef enum logic [IDX_W-1:0] {
      REG_LINE_MIN  = 3'd0,
      REG_LINE_MAX  = 3'd1,
      REG_SYNC_MIN  = 3'd2,
      REG_SYNC_MAX  = 3'd3,
      REG_VERT_OFF  = 3'd4,
      REG_FIRST_ROW = 3'd5
   } vslt_reg_type;

   typedef struct packed {
      logic [BOUND_W-1:0] line_pulse_min;
      logic [BOUND_W-1:0] line_pulse_max;
      logic [BOUND_W-1:0] sync_pulse_min;
      logic [BOUND_W-1:0] sync_pulse_max;
      logic [VOFF_W-1:0]  vertical_offset;
      logic [FROW_W-1:0]  first_display_row;
   } vslt_cfg_type;

   // Classified item handed from the input stage to the tracker.
   typedef struct packed {
      logic           valid;
      vslt_class_type pulse_class;
   } vslt_item_type;

   typedef struct packed {
      vslt_class_type    pulse_class;
      logic              render_valid;
      logic [ROW_W-1:0]  render_row;
      logic [FONT_W-1:0] render_font_line;
      logic              field_start;
      logic              frame_start;
      logic              field_end;
      logic              frame_end;
      logic              current_field;
      logic              pal_mode;
   } vslt_result_type;

endpackage

[rtl/vslt_if.sv]
// Channel interfaces of the video sync line tracker: pulse input and result output.
interface vslt_req_if import vslt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] pulse_ticks;

   modport source (output valid, output pulse_ticks, input ready);
   modport sink   (input valid, input pulse_ticks, output ready);
endinterface

interface vslt_rsp_if import vslt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        pulse_class;
   logic              render_valid;
   logic [ROW_W-1:0]  render_row;
   logic [FONT_W-1:0] render_font_line;
   logic              field_start;
   logic              frame_start;
   logic              field_end;
   logic              frame_end;
   logic              current_field;
   logic              pal_mode;

   modport source (output valid, output pulse_class, output render_valid,
                   output render_row, output render_font_line, output field_start,
                   output frame_start, output field_end, output frame_end,
                   output current_field, output pal_mode, input ready);
   modport sink   (input valid, input pulse_class, input render_valid,
                   input render_row, input render_font_line, input field_start,
                   input frame_start, input field_end, input frame_end,
                   input current_field, input pal_mode, output ready);
endinterface

[rtl/vslt_csr.sv]
// Configuration registers of the video sync line tracker.
module vslt_csr import vslt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_write_data,
   output vslt_cfg_type     cfg
);

   vslt_cfg_type cfg_ff;
   vslt_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (vslt_reg_type'(csr_index))
            REG_LINE_MIN:  cfg_in.line_pulse_min    = csr_write_data[BOUND_W-1:0];
            REG_LINE_MAX:  cfg_in.line_pulse_max    = csr_write_data[BOUND_W-1:0];
            REG_SYNC_MIN:  cfg_in.sync_pulse_min    = csr_write_data[BOUND_W-1:0];
            REG_SYNC_MAX:  cfg_in.sync_pulse_max    = csr_write_data[BOUND_W-1:0];
            REG_VERT_OFF:  cfg_in.vertical_offset   = csr_write_data[VOFF_W-1:0];
            REG_FIRST_ROW: cfg_in.first_display_row = csr_write_data[FROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/vslt_front.sv]
// Input register and pulse-width classifier of the video sync line tracker.
module vslt_front import vslt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   vslt_req_if.sink     req_bus,
   input  vslt_cfg_type cfg,
   input  logic         advance,
   output vslt_item_type item
);

   logic                      in_valid_ff;
   logic signed [PULSE_W-1:0] pulse_ff;
   logic                      line_hit;
   logic                      sync_hit;

   // Stage frees up whenever the tracker takes the held item.
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         pulse_ff <= req_bus.pulse_ticks;
      end
   end

   // Bounds are unsigned, so a negative width never lands in a window.
   assign line_hit = (pulse_ff > $signed({1'b0, cfg.line_pulse_min}))
                  && (pulse_ff < $signed({1'b0, cfg.line_pulse_max}));
   assign sync_hit = (pulse_ff > $signed({1'b0, cfg.sync_pulse_min}))
                  && (pulse_ff < $signed({1'b0, cfg.sync_pulse_max}));

   always_comb begin
      item.valid = in_valid_ff;
      if (line_hit) begin
         item.pulse_class = CLASS_LINE;
      end else if (sync_hit) begin
         item.pulse_class = CLASS_SYNC;
      end else begin
         item.pulse_class = CLASS_OTHER;
      end
   end

endmodule

[rtl/vslt_tracker.sv]
// Line, sync and display-area tracking state plus the result register.
module vslt_tracker import vslt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  vslt_cfg_type  cfg,
   input  vslt_item_type item,
   output logic          advance,
   vslt_rsp_if.source    rsp_bus
);

   logic [SCAN_W-1:0]  scan_ff,  scan_in;
   logic               field_ff, field_in;
   logic [SYNC_W-1:0]  sync_ff,  sync_in;
   logic [START_W-1:0] start_ff, start_in;
   logic [SCAN_W-1:0]  disp_ff,  disp_in;
   logic [LIMIT_W-1:0] last_ff,  last_in;
   logic [ROW_W-1:0]   row_ff,   row_in;
   logic [FONT_W-1:0]  font_ff,  font_in;
   logic [SCAN_W-1:0]  odd_ff,   odd_in;
   logic               out_valid_ff;
   vslt_result_type    result_ff, result_in;
   logic [FONT_W:0]    font_sum;
   logic               fire;

   assign advance = !out_valid_ff || rsp_bus.ready;
   assign fire    = item.valid && advance;
   assign font_sum = {1'b0, font_ff} + (FONT_W+1)'(1);

   always_comb begin
      scan_in  = scan_ff;
      field_in = field_ff;
      sync_in  = sync_ff;
      start_in = start_ff;
      disp_in  = disp_ff;
      last_in  = last_ff;
      row_in   = row_ff;
      font_in  = font_ff;
      odd_in   = odd_ff;
      result_in = '0;
      result_in.pulse_class = item.pulse_class;

      case (item.pulse_class)
         CLASS_LINE: begin
            if (scan_ff > SCAN_W'(start_ff)) begin
               if (disp_ff < SCAN_W'(last_ff)) begin
                  result_in.render_valid     = 1'b1;
                  result_in.render_row       = row_ff;
                  result_in.render_font_line = font_ff;
                  if (font_sum >= (FONT_W+1)'(GLYPH_HEIGHT)) begin
                     font_in = '0;
                     if (row_ff != ROW_MAX) row_in = row_ff + ROW_W'(1);
                  end else begin
                     font_in = font_sum[FONT_W-1:0];
                  end
               end else if (disp_ff == SCAN_W'(last_ff)) begin
                  if (row_ff != ROW_MAX) row_in = row_ff + ROW_W'(1);
                  result_in.field_end = 1'b1;
                  result_in.frame_end = field_ff;
               end
               if (disp_ff != SCAN_MAX) disp_in = disp_ff + SCAN_W'(1);
            end else begin
               // First line after a sync run settles mode and maybe the field.
               if (sync_ff != '0) begin
                  if (odd_ff == LINES_PAL) begin
                     field_in = (sync_ff != PAL_SYNC_RUN);
                     last_in  = PAL_LIMIT;
                  end else begin
                     last_in  = NTSC_LIMIT;
                  end
                  sync_in = '0;
               end
               if (scan_ff == SCAN_W'(start_ff)) begin
                  result_in.field_start = 1'b1;
                  result_in.frame_start = !field_in;
                  disp_in = '0;
                  row_in  = ROW_W'(cfg.first_display_row);
                  font_in = '0;
               end
            end
            if (scan_ff != SCAN_MAX) scan_in = scan_ff + SCAN_W'(1);
         end
         CLASS_SYNC: begin
            if (sync_ff == '0) begin
               if (scan_ff == LINES_SET_FIELD1) begin
                  field_in = 1'b1;
               end else if (scan_ff == LINES_SET_FIELD0) begin
                  field_in = 1'b0;
               end else if (scan_ff != LINES_PAL) begin
                  field_in = 1'b1;
               end
               if (field_in) odd_in = scan_ff;
               scan_in  = '0;
               start_in = START_W'(cfg.vertical_offset) + START_W'(1);
            end
            if (sync_ff != SYNC_MAX) sync_in = sync_ff + SYNC_W'(1);
         end
         default: ;
      endcase

      result_in.current_field = field_in;
      result_in.pal_mode      = (last_in == PAL_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         field_ff <= 1'b0;
         sync_ff  <= '0;
         start_ff <= '0;
         disp_ff  <= '0;
         last_ff  <= NTSC_LIMIT;
         row_ff   <= '0;
         font_ff  <= '0;
         odd_ff   <= '0;
      end else if (fire) begin
         scan_ff  <= scan_in;
         field_ff <= field_in;
         sync_ff  <= sync_in;
         start_ff <= start_in;
         disp_ff  <= disp_in;
         last_ff  <= last_in;
         row_ff   <= row_in;
         font_ff  <= font_in;
         odd_ff   <= odd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= item.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.pulse_class      = result_ff.pulse_class;
   assign rsp_bus.render_valid     = result_ff.render_valid;
   assign rsp_bus.render_row       = result_ff.render_row;
   assign rsp_bus.render_font_line = result_ff.render_font_line;
   assign rsp_bus.field_start      = result_ff.field_start;
   assign rsp_bus.frame_start      = result_ff.frame_start;
   assign rsp_bus.field_end        = result_ff.field_end;
   assign rsp_bus.frame_end        = result_ff.frame_end;
   assign rsp_bus.current_field    = result_ff.current_field;
   assign rsp_bus.pal_mode         = result_ff.pal_mode;

endmodule

[rtl/video_sync_line_tracker.sv]
// Top level of the video sync line tracker.
//
// Usage: each item on req_bus carries one measured pulse width (pulse_ticks,
// signed timer ticks). Each item yields exactly one result on rsp_bus: the
// pulse class, the character row and font line to draw when render_valid is
// set, field/frame start and end flags, the field flag and the PAL mode bit.
// The user must write window bounds, vertical offset and first row on the
// csr_ port only while no item is in flight; the block does not enforce it.
// An accepted item is loaded into the input register and, when the tracker
// advances, into the result register; rsp_bus.valid rises with the latter.
// Throughput: one item per cycle while rsp_bus.ready is high; the whole
// update is one pass of compares and counter steps between those registers.
// Reset clears all counters, the field flag and the configuration, and
// selects the NTSC line limit. When the receiver holds rsp_bus.ready low,
// the result register keeps its item and the input register can take one
// more item before req_bus.ready drops.
module video_sync_line_tracker import vslt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   vslt_req_if.sink         req_bus,
   vslt_rsp_if.source       rsp_bus,
   input  logic             csr_write_enable,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_write_data
);

   vslt_cfg_type  cfg;
   vslt_item_type item;
   logic          advance;

   vslt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   vslt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg),
      .advance (advance),
      .item    (item)
   );

   vslt_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item),
      .advance (advance),
      .rsp_bus (rsp_bus)
   );

endmodule

[rtl/vslt_checker.sv]
// Port-level checker of the video sync line tracker and its bind.
`include "video_sync_line_tracker_macros.svh"

module vslt_checker import vslt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        pulse_class,
   input logic              render_valid,
   input logic [ROW_W-1:0]  render_row,
   input logic [FONT_W-1:0] render_font_line,
   input logic              field_start,
   input logic              frame_start,
   input logic              field_end,
   input logic              frame_end,
   input logic              current_field,
   input logic              pal_mode
);

   logic [ROW_W+FONT_W+8:0] payload;

   assign payload = {pulse_class, render_valid, render_row, render_font_line, field_start,
                     frame_start, field_end, frame_end, current_field, pal_mode};

   // A stalled result must stay put.
   `VSLT_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(payload))

   // Drawing and display-area flags only come from line pulses.
   `VSLT_ASSERT_NOW(a_line_only, clock, reset,
      rsp_valid && (render_valid || field_start || field_end),
      pulse_class == CLASS_LINE)

   // Frame start is a field start on field zero.
   `VSLT_ASSERT_NOW(a_frame_start, clock, reset, rsp_valid && frame_start,
      field_start && !current_field && !render_valid)

   // Frame end is a field end on field one, and font line stays in the glyph.
   `VSLT_ASSERT_NOW(a_frame_end, clock, reset, rsp_valid && (frame_end || render_valid),
      (frame_end ? (field_end && current_field)
                 : (render_font_line < FONT_W'(GLYPH_HEIGHT))))

endmodule

bind video_sync_line_tracker vslt_checker u_vslt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .pulse_class      (rsp_bus.pulse_class),
   .render_valid     (rsp_bus.render_valid),
   .render_row       (rsp_bus.render_row),
   .render_font_line (rsp_bus.render_font_line),
   .field_start      (rsp_bus.field_start),
   .frame_start      (rsp_bus.frame_start),
   .field_end        (rsp_bus.field_end),
   .frame_end        (rsp_bus.frame_end),
   .current_field    (rsp_bus.current_field),
   .pal_mode         (rsp_bus.pal_mode)
);
